// ----- rtl/merge_sorter_assert.svh -----
// Assertion macros for the RTL that checks itself.
`ifndef MERGE_SORTER_ASSERT_SVH
`define MERGE_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define MS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define MS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/msort_pkg.sv -----
`timescale 1ns / 1ps
package msort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // One classified input item on its way from front to back.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              drop;
    } t_item;

endpackage

// ----- rtl/merge_sorter.sv -----
// Loading takes one item per cycle while the queue holds one; after the closing item,
// ceil(log2 n) merge passes run in two RAM banks, with a setup and a prime step per run pair.
// Emitting reads each result from RAM (registered read), then loads the output register.
// Reset (i_rst_n, synchronous, active low) clears control, counts and the queue;
// the value banks are not cleared.
`timescale 1ns / 1ps
`include "merge_sorter_assert.svh"
module merge_sorter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [msort_pkg::DATA_W-1:0]  i_value,
    input  logic                          i_is_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [msort_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    logic             w_push;
    logic             w_q_full;
    logic             w_q_valid;
    logic             w_q_pop;
    msort_pkg::t_item w_front_item;
    msort_pkg::t_item w_back_item;

    // Classify incoming transfers
    ms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_is_last (i_is_last),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    // Decouple front from the sort engine
    ms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_back_item)
    );

    // Store, sort and emit
    ms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_back_item),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    `MS_ASSERT_NOW(a_no_push_full, w_push, !w_q_full, "push into full queue")
    `MS_ASSERT_NOW(a_no_pop_empty, w_q_pop, w_q_valid, "pop from empty queue")
    `MS_ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid, "stalled result dropped")
    `MS_ASSERT_NEXT(a_hold_data, o_valid && i_stall, $stable(o_sorted_value), "data moved")

endmodule

// ----- rtl/ms_ram.sv -----
`timescale 1ns / 1ps
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read two words with registered outputs
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- rtl/ms_front.sv -----
`timescale 1ns / 1ps
module ms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [msort_pkg::DATA_W-1:0]  i_value,
    input  logic                          i_is_last,
    input  logic                          i_q_full,
    output logic                          o_push,
    output msort_pkg::t_item              o_item
);

    logic [msort_pkg::CNT_W-1:0] r_fcnt;
    logic [msort_pkg::CNT_W-1:0] n_fcnt;

    // Stall while the queue has no room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Classify: an item past capacity is marked for drop
    always_comb begin
        o_item.value = i_value;
        o_item.last  = i_is_last;
        o_item.drop  = (r_fcnt == msort_pkg::CNT_W'(msort_pkg::MAX_ITEMS));
    end

    // Count items of the current set, restart after the closing one
    always_comb begin
        n_fcnt = r_fcnt;
        if (o_push) begin
            if (i_is_last) begin
                n_fcnt = '0;
            end else if (!o_item.drop) begin
                n_fcnt = r_fcnt + msort_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
        end else begin
            r_fcnt <= n_fcnt;
        end
    end

endmodule

// ----- rtl/ms_queue.sv -----
`timescale 1ns / 1ps
module ms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  msort_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output msort_pkg::t_item  o_item
);

    msort_pkg::t_item              r_slot [msort_pkg::QUEUE_DEPTH];
    logic [msort_pkg::QPTR_W-1:0]  r_wptr;
    logic [msort_pkg::QPTR_W-1:0]  r_rptr;
    logic [msort_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == msort_pkg::QCNT_W'(msort_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + msort_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + msort_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + msort_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - msort_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/ms_back.sv -----
`timescale 1ns / 1ps
module ms_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  msort_pkg::t_item              i_q_item,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [msort_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_SETUP   = 3'd1;
    localparam logic [2:0] ST_PRIME   = 3'd2;
    localparam logic [2:0] ST_MERGE   = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_WR = 3'd5;

    localparam int CW = msort_pkg::CNT_W;
    localparam int IW = msort_pkg::IDX_W;
    localparam int DW = msort_pkg::DATA_W;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;
    logic [IW-1:0] r_i, n_i;
    logic          r_ovalid, n_ovalid;

    logic          w_we0, w_we1;
    logic [IW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [IW-1:0] w_raddr_a, w_raddr_b;
    logic [DW-1:0] w_rd0_a, w_rd0_b, w_rd1_a, w_rd1_b;
    logic [DW-1:0] w_da, w_db;
    logic          w_take_b;
    logic          w_out_load;
    logic [CW-1:0] w_cnt_inc;
    logic [CW-1:0] w_sum_mid, w_sum_hi;
    logic [CW-1:0] w_lo_next;
    logic [CW-1:0] w_width2;
    logic          w_emit_last;

    // Ping-pong banks: r_src selects the bank holding the current runs
    ms_ram #(.WIDTH(DW), .DEPTH(msort_pkg::MAX_ITEMS)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (w_we0),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd0_a),
        .o_rdata_b (w_rd0_b)
    );

    ms_ram #(.WIDTH(DW), .DEPTH(msort_pkg::MAX_ITEMS)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (w_we1),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd1_a),
        .o_rdata_b (w_rd1_b)
    );

    assign w_da = r_src ? w_rd1_a : w_rd0_a;
    assign w_db = r_src ? w_rd1_b : w_rd0_b;

    // Pick the right run head when the left run is spent or holds a larger value
    assign w_take_b = (r_a == r_mid) ||
                      ((r_b != r_hi) && ($signed(w_db) < $signed(w_da)));

    assign w_cnt_inc   = r_cnt + CW'(!i_q_item.drop);
    assign w_sum_mid   = r_lo + r_width;
    assign w_sum_hi    = r_lo + (r_width << 1);
    assign w_lo_next   = r_lo + (r_width << 1);
    assign w_width2    = r_width << 1;
    assign w_emit_last = ((CW'(r_i) + CW'(1)) == r_cnt);
    assign w_out_load  = (r_state == ST_EMIT_WR) && (!r_ovalid || !i_stall);

    // Sequencer: load, merge passes, emit
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_width  = r_width;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_src    = r_src;
        n_i      = r_i;
        o_q_pop  = 1'b0;
        w_we0    = 1'b0;
        w_we1    = 1'b0;
        w_waddr  = r_k[IW-1:0];
        w_wdata  = w_da;

        unique case (r_state)
            ST_LOAD: begin
                o_q_pop = i_q_valid;
                w_waddr = r_cnt[IW-1:0];
                w_wdata = i_q_item.value;
                if (i_q_valid) begin
                    if (i_q_item.drop) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_we0 = 1'b1;
                    end
                    n_cnt = w_cnt_inc;
                    if (i_q_item.last) begin
                        n_src   = 1'b0;
                        n_i     = '0;
                        n_width = CW'(1);
                        n_lo    = '0;
                        n_state = (w_cnt_inc > CW'(1)) ? ST_SETUP : ST_EMIT_RD;
                    end
                end
            end
            ST_SETUP: begin
                n_mid   = (w_sum_mid > r_cnt) ? r_cnt : w_sum_mid;
                n_hi    = (w_sum_hi > r_cnt) ? r_cnt : w_sum_hi;
                n_a     = r_lo;
                n_b     = (w_sum_mid > r_cnt) ? r_cnt : w_sum_mid;
                n_k     = r_lo;
                n_state = ST_PRIME;
            end
            ST_PRIME: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                w_we0   = r_src;
                w_we1   = !r_src;
                w_wdata = w_take_b ? w_db : w_da;
                if (w_take_b) begin
                    n_b = r_b + CW'(1);
                end else begin
                    n_a = r_a + CW'(1);
                end
                n_k = r_k + CW'(1);
                if ((r_k + CW'(1)) == r_hi) begin
                    if (w_lo_next >= r_cnt) begin
                        // Pass done: swap banks, double run width
                        n_src   = !r_src;
                        n_width = w_width2;
                        n_lo    = '0;
                        n_state = (w_width2 >= r_cnt) ? ST_EMIT_RD : ST_SETUP;
                    end else begin
                        n_lo    = w_lo_next;
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_out_load) begin
                    if (w_emit_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Read addresses: run heads while merging, output index while emitting
    always_comb begin
        if (r_state == ST_EMIT_RD || r_state == ST_EMIT_WR) begin
            w_raddr_a = r_i;
            w_raddr_b = r_i;
        end else begin
            w_raddr_a = n_a[IW-1:0];
            w_raddr_b = n_b[IW-1:0];
        end
    end

    // Output register valid: fill on load, drain on transfer
    always_comb begin
        n_ovalid = r_ovalid;
        if (w_out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_width  <= '0;
            r_lo     <= '0;
            r_mid    <= '0;
            r_hi     <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_k      <= '0;
            r_src    <= 1'b0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_width  <= n_width;
            r_lo     <= n_lo;
            r_mid    <= n_mid;
            r_hi     <= n_hi;
            r_a      <= n_a;
            r_b      <= n_b;
            r_k      <= n_k;
            r_src    <= n_src;
            r_i      <= n_i;
            r_ovalid <= n_ovalid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_sorted_value <= w_da;
            o_last_out     <= w_emit_last;
            o_overflow     <= r_ovf;
        end
    end

    assign o_valid = r_ovalid;

endmodule

// ----- test/merge_sorter_checker.sv -----
`timescale 1ns / 1ps
module merge_sorter_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [msort_pkg::DATA_W-1:0]  i_value,
    input  logic                          i_is_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [msort_pkg::DATA_W-1:0]  i_sorted_value,
    input  logic                          i_last_out,
    input  logic                          i_overflow,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int DATA_W    = msort_pkg::DATA_W;
    localparam int MAX_ITEMS = msort_pkg::MAX_ITEMS;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last_out;
        logic              overflow;
    } t_sorted_entry;

    // Values of the set being loaded, and the sorted results still owed
    logic signed [DATA_W-1:0] set_values[$];
    logic                     set_overflow;
    t_sorted_entry            sorted_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        set_overflow = 1'b0;
    end

    // Sort the closed set in signed ascending order and queue its results
    task automatic close_set();
        logic signed [DATA_W-1:0] ordered[$];
        logic signed [DATA_W-1:0] key;
        t_sorted_entry            entry;
        int                       i;
        int                       j;
        ordered = set_values;
        for (i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j   = i - 1;
            while (j >= 0 && ordered[j] > key) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        for (i = 0; i < ordered.size(); i++) begin
            entry.value    = ordered[i];
            entry.last_out = (i == ordered.size() - 1);
            entry.overflow = set_overflow;
            sorted_due.push_back(entry);
        end
        set_values.delete();
        set_overflow = 1'b0;
    endtask

    always @(posedge i_clk) begin : watch
        t_sorted_entry want;
        if (i_rst_n) begin
            // Load the input transfer, drop it once the store is full
            if (i_in_valid && !i_in_stall) begin
                if (set_values.size() < MAX_ITEMS) begin
                    set_values.push_back(i_value);
                end else begin
                    set_overflow = 1'b1;
                end
                if (i_is_last) begin
                    close_set();
                end
            end

            // Compare the output transfer with the oldest sorted result
            if (i_out_valid && !i_out_stall) begin
                if (sorted_due.size() == 0) begin
                    $error("unexpected result: sorted_value %0d, last_out %0b, overflow %0b",
                           $signed(i_sorted_value), i_last_out, i_overflow);
                    o_fail_count++;
                end else begin
                    want = sorted_due.pop_front();
                    if (want.value !== i_sorted_value) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(i_sorted_value));
                        o_fail_count++;
                    end
                    if (want.last_out !== i_last_out) begin
                        $error("last_out: expected %0b, actual %0b", want.last_out, i_last_out);
                        o_fail_count++;
                    end
                    if (want.overflow !== i_overflow) begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, i_overflow);
                        o_fail_count++;
                    end
                end
            end
            o_pending = sorted_due.size();
        end
    end

endmodule

// ----- test/tb_merge_sorter.sv -----
`timescale 1ns / 1ps
module tb_merge_sorter;

    localparam int DATA_W       = msort_pkg::DATA_W;
    localparam int MAX_ITEMS    = msort_pkg::MAX_ITEMS;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEM_TARGET  = 450;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [DATA_W-1:0] i_value;
    logic              i_is_last;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_sorted_value;
    logic              o_last_out;
    logic              o_overflow;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int items_sent   = 0;
    bit hold_request = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    merge_sorter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    merge_sorter_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_value        (i_value),
        .i_is_last      (i_is_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_sorted_value (o_sorted_value),
        .i_last_out     (o_last_out),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // Mix extremes, small duplicates and full-range values
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until the transfer; idle between bursts
    task automatic send_item(input logic [DATA_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 20);
            i_valid   <= 1'b0;
            i_value   <= $urandom();
            i_is_last <= 1'($urandom_range(1));
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_value   <= value;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("merge_sorter regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stall on a changing pattern, or hold off on request
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          run_left;
        logic        run_stall;
        int          hold_cnt;
        mode      = STALL_NONE;
        mode_left = 0;
        run_left  = 0;
        run_stall = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(3) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_stall = ~run_stall;
                            run_left  = $urandom_range(1, 12);
                        end
                        run_left--;
                        i_stall <= run_stall;
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int set_len;
        int set_idx;
        int kind;
        int k;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_value   <= '0;
        i_is_last <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-value sets at both extremes
        send_item(32'h7fff_ffff, 1'b1);
        send_item(32'h8000_0000, 1'b1);

        // Extremes, zero, minus one and duplicates in one set
        send_item(32'd5, 1'b0);
        send_item(-32'sd3, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd0, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'd5, 1'b1);

        // Already ordered and reversed pairs
        send_item(32'd1, 1'b0);
        send_item(32'd2, 1'b1);
        send_item(32'd2, 1'b0);
        send_item(32'd1, 1'b1);

        // All values equal
        send_item(-32'sd7, 1'b0);
        send_item(-32'sd7, 1'b0);
        send_item(-32'sd7, 1'b0);
        send_item(-32'sd7, 1'b1);

        // Random sets: mostly short, some full, some overflowing the store
        set_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(15);
            if (set_idx == 2) begin
                hold_request = 1'b1;
                set_len      = MAX_ITEMS + 6;
            end else if (kind == 0) begin
                set_len = MAX_ITEMS + $urandom_range(1, 8);
            end else if (kind == 1) begin
                set_len = MAX_ITEMS;
            end else if (kind == 2) begin
                set_len = MAX_ITEMS - 1;
            end else begin
                set_len = $urandom_range(1, 12);
            end
            for (k = 0; k < set_len; k++) begin
                send_item(pick_value(), k == set_len - 1);
            end
            set_idx++;
        end

        // Drain the results, then give the verdict
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("merge_sorter regression: pass");
        end else begin
            $display("merge_sorter regression: fail");
        end
        $finish;
    end

endmodule
